@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the frame decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("%m: assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

@@ rtl/lfd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfd_pkg
// Types and constants shared by the length-field frame decoder modules.
// ----------------------------------------------------------------------------
package lfd_pkg;

    // Frame size and byte counter width.
    localparam int unsigned FRAME_BITS     = 32;
    // Width of the length field offset register.
    localparam int unsigned OFFSET_BITS    = 16;
    // Field end (offset plus field size) needs one more bit than the offset.
    localparam int unsigned FE_BITS        = OFFSET_BITS + 1;
    localparam int unsigned LEN_BYTES_BITS = 4;
    localparam int unsigned ADJ_BITS       = 32;
    localparam int unsigned BYTE_BITS      = 8;
    localparam int unsigned ACCUM_BITS     = 64;
    localparam int unsigned ACCUM_LANES    = ACCUM_BITS / BYTE_BITS;
    localparam int unsigned LANE_SEL_BITS  = $clog2(ACCUM_LANES);
    // Low part of the declared length that takes part in the size arithmetic.
    // A declared length at or above 2**LOW_BITS always gives a boundary error.
    localparam int unsigned LOW_BITS       = FRAME_BITS + 1;
    // Signed width that holds every size sum and every size threshold.
    localparam int unsigned SUM_BITS       = LOW_BITS + 2;

    localparam int unsigned CFG_INDEX_BITS = 3;
    localparam int unsigned CFG_DATA_BITS  = 32;
    localparam int unsigned TUSER_BITS     = 4;
    localparam int unsigned TDATA_BITS     = BYTE_BITS + FRAME_BITS + ACCUM_BITS;

    localparam logic [LEN_BYTES_BITS-1:0] LEN_BYTES_MAX = LEN_BYTES_BITS'(8);

    // Register values after reset.
    localparam logic [OFFSET_BITS-1:0]    RST_LENGTH_OFFSET = '0;
    localparam logic [LEN_BYTES_BITS-1:0] RST_LENGTH_BYTES  = LEN_BYTES_BITS'(4);
    localparam logic                      RST_BIG_ENDIAN    = 1'b1;
    localparam logic [ADJ_BITS-1:0]       RST_LENGTH_ADJUST = '0;
    localparam logic [FRAME_BITS-1:0]     RST_STRIP_BYTES   = FRAME_BITS'(4);
    localparam logic [FRAME_BITS-1:0]     RST_MAX_FRAME     = FRAME_BITS'(1024 * 1024);

    // Cycles after a register write before the derived limits are current.
    localparam logic [1:0] SETTLE_CYCLES = 2'd2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_LENGTH_OFFSET = 3'd0,
        CFG_LENGTH_BYTES  = 3'd1,
        CFG_BIG_ENDIAN    = 3'd2,
        CFG_LENGTH_ADJUST = 3'd3,
        CFG_STRIP_BYTES   = 3'd4,
        CFG_MAX_FRAME     = 3'd5
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_COLLECT    = 3'd0,
        ST_COMPLETE   = 3'd1,
        ST_BOUNDARY   = 3'd2,
        ST_NEGATIVE   = 3'd3,
        ST_OVER_LIMIT = 3'd4,
        ST_BAD_CONFIG = 3'd5
    } status_t;

    // Configuration and precomputed size limits handed to the datapath.
    // The limit fields hold two's complement values of SUM_BITS bits.
    typedef struct packed {
        logic [OFFSET_BITS-1:0] offset;
        logic                   big_endian;
        logic [FRAME_BITS-1:0]  strip;
        logic [FE_BITS-1:0]     fe;
        logic [FE_BITS-1:0]     fe_m1;
        logic [SUM_BITS-1:0]    k;
        logic [SUM_BITS-1:0]    km1;
        logic [SUM_BITS-1:0]    t_neg;
        logic [SUM_BITS-1:0]    t_fe;
        logic [SUM_BITS-1:0]    t_strip;
        logic [SUM_BITS-1:0]    t_max;
        logic [SUM_BITS-1:0]    t_big;
        logic                   bad;
        logic                   settled;
    } lfd_cfg_t;

endpackage

@@ rtl/length_field_frame_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_field_frame_decoder
// Cuts a byte stream into frames framed by an embedded length field.
// ----------------------------------------------------------------------------
// Bytes enter on the s_t* stream, one per transfer. Each byte leaves on the
// m_t* stream with its payload mark and status in m_tuser, the frame end in
// m_tlast, and the computed frame size and raw length field in m_tdata.
// The cfg_* channel writes the six frame registers by index; it is always
// ready. A write is meant for an idle block, between frames or before traffic.
// The block sustains one byte per cycle while the receiver is ready and no
// register write or settling holds it off: the byte passes through the input
// register, then the size checks run in a single pass into the result
// register. The size checks compare the field value against limits that are
// precomputed from the registers in two stages, so s_tready stays low while
// cfg_valid is high and after each write until both stages are current; the
// same hold follows reset, which also clears all frame state and any error.
// When the receiver stalls, the result register holds its transfer and the
// input register takes one more byte before s_tready drops.
// Once an error is latched, bytes still flow through, unmarked and carrying
// the error status, until the next reset.
// ----------------------------------------------------------------------------
module length_field_frame_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    // Fields from bit 0: data_byte[7:0].
    input  logic [lfd_pkg::BYTE_BITS-1:0]       s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: out_byte[7:0], frame_total[39:8], declared_length[103:40].
    output logic [lfd_pkg::TDATA_BITS-1:0]      m_tdata,
    // Fields from bit 0: is_payload[0], status[3:1].
    output logic [lfd_pkg::TUSER_BITS-1:0]      m_tuser,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lfd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [lfd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    lfd_pkg::lfd_cfg_t              cfg;
    logic                           in_valid_reg, in_valid_next;
    logic [lfd_pkg::BYTE_BITS-1:0]  in_byte_reg;
    logic                           take;
    logic                           s_accept;

    lfd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Register writes never share an edge with an input transfer, and new input
    // waits until the derived limits reflect the latest write.
    assign cfg_ready = 1'b1;
    assign s_tready  = !cfg_valid && cfg.settled && (!in_valid_reg || take);
    assign s_accept  = s_tvalid && s_tready;

    always_comb
    begin
        if (s_accept)
            in_valid_next = 1'b1;
        else if (take)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
            in_byte_reg <= s_tdata;
    end

    lfd_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_valid_reg),
        .in_byte  (in_byte_reg),
        .take     (take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

@@ rtl/lfd_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfd_cfg
// Configuration registers and the registered size limits derived from them.
// ----------------------------------------------------------------------------
module lfd_cfg (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    input  logic [lfd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [lfd_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    output lfd_pkg::lfd_cfg_t                     cfg
);

    logic [lfd_pkg::OFFSET_BITS-1:0]    offset_reg, offset_next;
    logic [lfd_pkg::LEN_BYTES_BITS-1:0] bytes_reg, bytes_next;
    logic                               big_reg, big_next;
    logic [lfd_pkg::ADJ_BITS-1:0]       adjust_reg, adjust_next;
    logic [lfd_pkg::FRAME_BITS-1:0]     strip_reg, strip_next;
    logic [lfd_pkg::FRAME_BITS-1:0]     max_reg, max_next;
    logic [1:0]                         settle_reg, settle_next;

    // First derived stage.
    logic [lfd_pkg::FE_BITS-1:0]         fe_reg, fe_next;
    logic signed [lfd_pkg::SUM_BITS-1:0] k_reg, k_next;
    logic signed [lfd_pkg::SUM_BITS-1:0] t_fe_reg, t_fe_next;
    logic                                bad1_reg, bad1_next;

    // Second derived stage.
    logic [lfd_pkg::FE_BITS-1:0]         fe_m1_reg, fe_m1_next;
    logic signed [lfd_pkg::SUM_BITS-1:0] km1_reg, km1_next;
    logic signed [lfd_pkg::SUM_BITS-1:0] t_neg_reg, t_neg_next;
    logic signed [lfd_pkg::SUM_BITS-1:0] t_strip_reg, t_strip_next;
    logic signed [lfd_pkg::SUM_BITS-1:0] t_max_reg, t_max_next;
    logic signed [lfd_pkg::SUM_BITS-1:0] t_big_reg, t_big_next;
    logic                                bad_reg, bad_next;

    logic signed [lfd_pkg::SUM_BITS-1:0] offset_ext, bytes_ext, adjust_ext;
    logic signed [lfd_pkg::SUM_BITS-1:0] strip_ext, max_ext, frame_lim;

    always_comb
    begin
        offset_next = offset_reg;
        bytes_next  = bytes_reg;
        big_next    = big_reg;
        adjust_next = adjust_reg;
        strip_next  = strip_reg;
        max_next    = max_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                lfd_pkg::CFG_LENGTH_OFFSET:
                    offset_next = cfg_data[lfd_pkg::OFFSET_BITS-1:0];
                lfd_pkg::CFG_LENGTH_BYTES:
                    bytes_next = cfg_data[lfd_pkg::LEN_BYTES_BITS-1:0];
                lfd_pkg::CFG_BIG_ENDIAN:
                    big_next = cfg_data[0];
                lfd_pkg::CFG_LENGTH_ADJUST:
                    adjust_next = cfg_data[lfd_pkg::ADJ_BITS-1:0];
                lfd_pkg::CFG_STRIP_BYTES:
                    strip_next = cfg_data[lfd_pkg::FRAME_BITS-1:0];
                lfd_pkg::CFG_MAX_FRAME:
                    max_next = cfg_data[lfd_pkg::FRAME_BITS-1:0];
                default:
                    ;
            endcase
        end

        // Data is held off while the limits below catch up with a write.
        if (cfg_valid)
            settle_next = lfd_pkg::SETTLE_CYCLES;
        else if (settle_reg != 2'd0)
            settle_next = settle_reg - 2'd1;
        else
            settle_next = settle_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= lfd_pkg::RST_LENGTH_OFFSET;
            bytes_reg  <= lfd_pkg::RST_LENGTH_BYTES;
            big_reg    <= lfd_pkg::RST_BIG_ENDIAN;
            adjust_reg <= lfd_pkg::RST_LENGTH_ADJUST;
            strip_reg  <= lfd_pkg::RST_STRIP_BYTES;
            max_reg    <= lfd_pkg::RST_MAX_FRAME;
            settle_reg <= lfd_pkg::SETTLE_CYCLES;
        end
        else
        begin
            offset_reg <= offset_next;
            bytes_reg  <= bytes_next;
            big_reg    <= big_next;
            adjust_reg <= adjust_next;
            strip_reg  <= strip_next;
            max_reg    <= max_next;
            settle_reg <= settle_next;
        end
    end

    // With K = field end + adjust, the frame size is S = L + K for the low part
    // L of the declared length, and every size check becomes a compare of L
    // against a limit that depends on the registers alone.
    always_comb
    begin
        offset_ext = $signed({{(lfd_pkg::SUM_BITS - lfd_pkg::OFFSET_BITS){1'b0}}, offset_reg});
        bytes_ext  = $signed({{(lfd_pkg::SUM_BITS - lfd_pkg::LEN_BYTES_BITS){1'b0}}, bytes_reg});
        adjust_ext = $signed({{(lfd_pkg::SUM_BITS - lfd_pkg::ADJ_BITS){adjust_reg[lfd_pkg::ADJ_BITS-1]}},
                              adjust_reg});
        strip_ext  = $signed({{(lfd_pkg::SUM_BITS - lfd_pkg::FRAME_BITS){1'b0}}, strip_reg});
        max_ext    = $signed({{(lfd_pkg::SUM_BITS - lfd_pkg::FRAME_BITS){1'b0}}, max_reg});
        frame_lim  = $signed({{(lfd_pkg::SUM_BITS - lfd_pkg::FRAME_BITS){1'b0}},
                              {lfd_pkg::FRAME_BITS{1'b1}}});

        fe_next   = lfd_pkg::FE_BITS'(offset_reg) + lfd_pkg::FE_BITS'(bytes_reg);
        k_next    = offset_ext + bytes_ext + adjust_ext;
        t_fe_next = -adjust_ext;
        bad1_next = (bytes_reg == '0) || (bytes_reg > lfd_pkg::LEN_BYTES_MAX) ||
                    (max_reg == '0) || (strip_reg > max_reg);

        fe_m1_next   = fe_reg - lfd_pkg::FE_BITS'(1);
        km1_next     = k_reg - lfd_pkg::SUM_BITS'(1);
        t_neg_next   = -k_reg;
        t_strip_next = strip_ext - k_reg;
        t_max_next   = max_ext - k_reg;
        t_big_next   = frame_lim - k_reg;
        bad_next     = bad1_reg || (lfd_pkg::FRAME_BITS'(fe_reg) > max_reg);
    end

    always_ff @(posedge clk)
    begin
        fe_reg      <= fe_next;
        k_reg       <= k_next;
        t_fe_reg    <= t_fe_next;
        bad1_reg    <= bad1_next;
        fe_m1_reg   <= fe_m1_next;
        km1_reg     <= km1_next;
        t_neg_reg   <= t_neg_next;
        t_strip_reg <= t_strip_next;
        t_max_reg   <= t_max_next;
        t_big_reg   <= t_big_next;
        bad_reg     <= bad_next;
    end

    always_comb
    begin
        cfg.offset     = offset_reg;
        cfg.big_endian = big_reg;
        cfg.strip      = strip_reg;
        cfg.fe         = fe_reg;
        cfg.fe_m1      = fe_m1_reg;
        cfg.k          = k_reg;
        cfg.km1        = km1_reg;
        cfg.t_neg      = t_neg_reg;
        cfg.t_fe       = t_fe_reg;
        cfg.t_strip    = t_strip_reg;
        cfg.t_max      = t_max_reg;
        cfg.t_big      = t_big_reg;
        cfg.bad        = bad_reg;
        cfg.settled    = (settle_reg == 2'd0);
    end

endmodule

@@ rtl/lfd_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfd_core
// Per-byte frame tracking, size validation and the registered result stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfd_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lfd_pkg::lfd_cfg_t                   cfg,
    input  logic                                in_valid,
    input  logic [lfd_pkg::BYTE_BITS-1:0]       in_byte,
    output logic                                take,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lfd_pkg::TDATA_BITS-1:0]      m_tdata,
    output logic                                m_tlast,
    output logic [lfd_pkg::TUSER_BITS-1:0]      m_tuser
);

    // Frame state.
    logic [lfd_pkg::FRAME_BITS-1:0] pos_reg, pos_next;
    logic [lfd_pkg::ACCUM_BITS-1:0] accum_reg, accum_next;
    logic [lfd_pkg::FRAME_BITS-1:0] size_reg, size_next;
    logic [lfd_pkg::FRAME_BITS-1:0] last_reg, last_next;
    logic                           known_reg, known_next;
    lfd_pkg::status_t               err_reg, err_next;

    // Result register.
    logic                           out_valid_reg, out_valid_next;
    logic [lfd_pkg::BYTE_BITS-1:0]  res_byte_reg;
    logic                           res_payload_reg;
    logic                           res_fend_reg;
    lfd_pkg::status_t               res_status_reg;
    logic [lfd_pkg::FRAME_BITS-1:0] res_total_reg;
    logic [lfd_pkg::ACCUM_BITS-1:0] res_decl_reg;

    // Datapath.
    logic                                   bad_now;
    lfd_pkg::status_t                       err_cur;
    logic                                   in_field;
    logic                                   field_last;
    logic [lfd_pkg::LANE_SEL_BITS-1:0]      lane_sel;
    logic [lfd_pkg::ACCUM_BITS-1:0]         accum_le;
    logic [lfd_pkg::ACCUM_BITS-1:0]         accum_upd;
    logic [lfd_pkg::ACCUM_BITS-1:0]         accum_new;
    logic                                   hi_nz;
    logic signed [lfd_pkg::SUM_BITS-1:0]    low_val;
    logic signed [lfd_pkg::SUM_BITS-1:0]    size_sum;
    logic signed [lfd_pkg::SUM_BITS-1:0]    last_sum;
    logic [lfd_pkg::FRAME_BITS-1:0]         size_calc;
    logic [lfd_pkg::FRAME_BITS-1:0]         last_calc;
    lfd_pkg::status_t                       size_err;
    lfd_pkg::status_t                       check_err;
    logic                                   end_hit;
    logic                                   payload_c;
    logic                                   fend_c;
    lfd_pkg::status_t                       status_c;
    logic [lfd_pkg::FRAME_BITS-1:0]         total_c;
    logic [lfd_pkg::ACCUM_BITS-1:0]         decl_c;

    assign take = in_valid && (!out_valid_reg || m_tready);

    // Field capture and size checks.
    always_comb
    begin
        bad_now = (err_reg == lfd_pkg::ST_COLLECT) && cfg.bad;
        err_cur = bad_now ? lfd_pkg::ST_BAD_CONFIG : err_reg;

        in_field = (pos_reg >= lfd_pkg::FRAME_BITS'(cfg.offset)) &&
                   (pos_reg < lfd_pkg::FRAME_BITS'(cfg.fe));
        field_last = in_field && (pos_reg == lfd_pkg::FRAME_BITS'(cfg.fe_m1));

        // Little-endian bytes land in the lane given by their place in the field.
        lane_sel = pos_reg[lfd_pkg::LANE_SEL_BITS-1:0] - cfg.offset[lfd_pkg::LANE_SEL_BITS-1:0];
        for (int i = 0; i < lfd_pkg::ACCUM_LANES; i++)
        begin
            accum_le[i*lfd_pkg::BYTE_BITS +: lfd_pkg::BYTE_BITS] =
                accum_reg[i*lfd_pkg::BYTE_BITS +: lfd_pkg::BYTE_BITS] |
                ((lane_sel == lfd_pkg::LANE_SEL_BITS'(i)) ? in_byte : '0);
        end
        accum_upd = cfg.big_endian ?
                    {accum_reg[lfd_pkg::ACCUM_BITS-lfd_pkg::BYTE_BITS-1:0], in_byte} :
                    accum_le;
        accum_new = in_field ? accum_upd : accum_reg;

        hi_nz   = |accum_new[lfd_pkg::ACCUM_BITS-1:lfd_pkg::LOW_BITS];
        low_val = $signed({{(lfd_pkg::SUM_BITS - lfd_pkg::LOW_BITS){1'b0}},
                           accum_new[lfd_pkg::LOW_BITS-1:0]});

        size_sum  = low_val + $signed(cfg.k);
        last_sum  = low_val + $signed(cfg.km1);
        size_calc = size_sum[lfd_pkg::FRAME_BITS-1:0];
        last_calc = last_sum[lfd_pkg::FRAME_BITS-1:0];

        // Order matters: overflow, then a negative size, then the boundary
        // checks, and the size limit last.
        priority if (hi_nz)
            check_err = lfd_pkg::ST_BOUNDARY;
        else if (low_val < $signed(cfg.t_neg))
            check_err = lfd_pkg::ST_NEGATIVE;
        else if ((low_val > $signed(cfg.t_big)) || (low_val < $signed(cfg.t_fe)) ||
                 (low_val < $signed(cfg.t_strip)))
            check_err = lfd_pkg::ST_BOUNDARY;
        else if (low_val > $signed(cfg.t_max))
            check_err = lfd_pkg::ST_OVER_LIMIT;
        else
            check_err = lfd_pkg::ST_COLLECT;

        size_err = field_last ? check_err : lfd_pkg::ST_COLLECT;

        // On the byte that completes the field, the frame also ends there when
        // the size equals the field end, which is the case L + adjust == 0.
        end_hit = known_reg ? (pos_reg == last_reg) :
                  (field_last && (low_val == $signed(cfg.t_fe)));
    end

    // Next state and result.
    always_comb
    begin
        pos_next   = pos_reg;
        accum_next = accum_reg;
        size_next  = size_reg;
        last_next  = last_reg;
        known_next = known_reg;
        err_next   = err_reg;
        payload_c  = 1'b0;
        fend_c     = 1'b0;
        status_c   = lfd_pkg::ST_COLLECT;
        total_c    = '0;
        decl_c     = '0;

        if (err_cur != lfd_pkg::ST_COLLECT)
        begin
            err_next = err_cur;
            status_c = err_cur;
            decl_c   = (err_cur == lfd_pkg::ST_BAD_CONFIG) ? '0 : accum_reg;
        end
        else
        begin
            payload_c  = (pos_reg >= cfg.strip);
            accum_next = accum_new;
            if (size_err != lfd_pkg::ST_COLLECT)
            begin
                err_next = size_err;
                status_c = size_err;
                decl_c   = accum_new;
            end
            else
            begin
                if (pos_reg >= lfd_pkg::FRAME_BITS'(cfg.fe_m1))
                    decl_c = accum_new;
                if (known_reg || field_last)
                begin
                    total_c = known_reg ? size_reg : size_calc;
                    if (end_hit)
                    begin
                        fend_c     = 1'b1;
                        status_c   = lfd_pkg::ST_COMPLETE;
                        pos_next   = '0;
                        accum_next = '0;
                        size_next  = '0;
                        last_next  = '0;
                        known_next = 1'b0;
                    end
                    else
                    begin
                        pos_next = pos_reg + lfd_pkg::FRAME_BITS'(1);
                        if (field_last)
                        begin
                            size_next  = size_calc;
                            last_next  = last_calc;
                            known_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    pos_next = pos_reg + lfd_pkg::FRAME_BITS'(1);
                end
            end
        end

        if (take)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            accum_reg     <= '0;
            size_reg      <= '0;
            last_reg      <= '0;
            known_reg     <= 1'b0;
            err_reg       <= lfd_pkg::ST_COLLECT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                pos_reg   <= pos_next;
                accum_reg <= accum_next;
                size_reg  <= size_next;
                last_reg  <= last_next;
                known_reg <= known_next;
                err_reg   <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_byte_reg    <= in_byte;
            res_payload_reg <= payload_c;
            res_fend_reg    <= fend_c;
            res_status_reg  <= status_c;
            res_total_reg   <= total_c;
            res_decl_reg    <= decl_c;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {res_decl_reg, res_total_reg, res_byte_reg};
    assign m_tlast  = res_fend_reg;
    assign m_tuser  = {res_status_reg, res_payload_reg};

    `ASSERT_NEXT(a_err_sticky, clk, rst_n, err_reg != lfd_pkg::ST_COLLECT, err_reg == $past(err_reg))
    `ASSERT_IMPL(a_known_in_frame, clk, rst_n, known_reg, (pos_reg < size_reg) && ((last_reg + lfd_pkg::FRAME_BITS'(1)) == size_reg))
    `ASSERT_NEXT(a_frame_restart, clk, rst_n, take && fend_c, (pos_reg == '0) && !known_reg)
    `ASSERT_IMPL(a_err_unmarked, clk, rst_n, take && (err_reg != lfd_pkg::ST_COLLECT), !payload_c && !fend_c)

endmodule
